[sv/rpn_pkg.sv]
// Shared types, widths and command codes for the postfix stack evaluator.
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

	localparam int WORD_W      = 32;
	localparam int CMD_W       = 5;
	localparam int DEPTH_OUT_W = 5;
	localparam int ERR_W       = 8;
	localparam int SH_W        = $clog2(WORD_W);
	localparam int DIV_CNT_W   = $clog2(WORD_W + 1);

	localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

	localparam logic [CMD_W-1:0] CMD_PUSH_LIT  = 5'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_TIME = 5'd1;
	localparam logic [CMD_W-1:0] CMD_ADD       = 5'd2;
	localparam logic [CMD_W-1:0] CMD_SUB       = 5'd3;
	localparam logic [CMD_W-1:0] CMD_MUL       = 5'd4;
	localparam logic [CMD_W-1:0] CMD_DIV       = 5'd5;
	localparam logic [CMD_W-1:0] CMD_SHL       = 5'd6;
	localparam logic [CMD_W-1:0] CMD_SHR       = 5'd7;
	localparam logic [CMD_W-1:0] CMD_AND       = 5'd8;
	localparam logic [CMD_W-1:0] CMD_NOT       = 5'd9;
	localparam logic [CMD_W-1:0] CMD_XOR       = 5'd10;
	localparam logic [CMD_W-1:0] CMD_OR        = 5'd11;
	localparam logic [CMD_W-1:0] CMD_EQ        = 5'd12;
	localparam logic [CMD_W-1:0] CMD_NE        = 5'd13;
	localparam logic [CMD_W-1:0] CMD_GT        = 5'd14;
	localparam logic [CMD_W-1:0] CMD_LT        = 5'd15;
	localparam logic [CMD_W-1:0] CMD_LE        = 5'd16;
	localparam logic [CMD_W-1:0] CMD_GE        = 5'd17;
	localparam logic [CMD_W-1:0] CMD_MOD       = 5'd18;
	localparam logic [CMD_W-1:0] CMD_LAND      = 5'd19;
	localparam logic [CMD_W-1:0] CMD_LOR       = 5'd20;

	typedef logic [WORD_W-1:0] word_t;

	// Source a stack cell loads from on the next edge
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_UP,
		CELL_FROM_DOWN
	} cell_sel_t;

	typedef struct packed {
		logic  start;
		word_t dividend;
		word_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		word_t quotient;
		word_t remainder;
	} div_rsp_t;

endpackage

`default_nettype wire

[sv/rpn_in_if.sv]
// Command channel: valid/ready handshake with command, literal and time value.
`timescale 1ns / 1ps
`default_nettype none

interface rpn_in_if import rpn_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	word_t            literal;
	word_t            time_value;

	modport source (output valid, output cmd, output literal, output time_value, input ready);
	modport sink   (input valid, input cmd, input literal, input time_value, output ready);

endinterface

`default_nettype wire

[sv/rpn_out_if.sv]
// Result channel: valid/ready handshake with top value, depth and error count.
`timescale 1ns / 1ps
`default_nettype none

interface rpn_out_if import rpn_pkg::*; ();

	logic                   valid;
	logic                   ready;
	word_t                  top_value;
	logic [DEPTH_OUT_W-1:0] stack_depth;
	logic [ERR_W-1:0]       error_count;

	modport source (output valid, output top_value, output stack_depth, output error_count,
		input ready);
	modport sink   (input valid, input top_value, input stack_depth, input error_count,
		output ready);

endinterface

`default_nettype wire

[sv/rpn_cell.sv]
// One stack cell: holds a word, or loads from the cell above or below.
`timescale 1ns / 1ps
`default_nettype none

module rpn_cell import rpn_pkg::*; (
	input  wire logic      clk,
	input  wire cell_sel_t sel,
	input  wire word_t     from_up,
	input  wire word_t     from_down,
	output word_t          value
);

	word_t value_q;

	// Hold, shift down on push, shift up on pop
	always_ff @(posedge clk) begin
		case (sel)
			CELL_FROM_UP:   value_q <= from_up;
			CELL_FROM_DOWN: value_q <= from_down;
			default:        value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

`default_nettype wire

[sv/rpn_alu.sv]
// Combinational operators: arithmetic, shifts, bitwise, compares and logic.
`timescale 1ns / 1ps
`default_nettype none

module rpn_alu import rpn_pkg::*; (
	input  wire logic [CMD_W-1:0] cmd,
	input  wire word_t            a,
	input  wire word_t            b,
	output word_t                 result
);

	logic big_shift;

	assign big_shift = |b[WORD_W-1:SH_W];

	// Divide and modulo come from the divider; here they give the zero-divisor result
	always_comb begin
		case (cmd)
			CMD_ADD:  result = a + b;
			CMD_SUB:  result = a - b;
			CMD_MUL:  result = a * b;
			CMD_SHL:  result = big_shift ? '0 : (a << b[SH_W-1:0]);
			CMD_SHR:  result = big_shift ? '0 : (a >> b[SH_W-1:0]);
			CMD_AND:  result = a & b;
			CMD_NOT:  result = ~b;
			CMD_XOR:  result = a ^ b;
			CMD_OR:   result = a | b;
			CMD_EQ:   result = word_t'(a == b);
			CMD_NE:   result = word_t'(a != b);
			CMD_GT:   result = word_t'(a > b);
			CMD_LT:   result = word_t'(a < b);
			CMD_LE:   result = word_t'(a <= b);
			CMD_GE:   result = word_t'(a >= b);
			CMD_LAND: result = word_t'((|a) && (|b));
			CMD_LOR:  result = word_t'((|a) || (|b));
			default:  result = '0;
		endcase
	end

endmodule

`default_nettype wire

[sv/rpn_div.sv]
// Restoring divider: one quotient bit per cycle, quotient and remainder out.
`timescale 1ns / 1ps
`default_nettype none

module rpn_div import rpn_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	word_t                rem_q;
	word_t                quo_q;
	word_t                divisor_q;
	logic [WORD_W:0]      trial;
	logic                 done;

	assign trial = {rem_q, quo_q[WORD_W-1]} - {1'b0, divisor_q};
	assign done  = busy_q && (cnt_q == '0);

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(WORD_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q && !done) begin
			if (!trial[WORD_W]) begin
				rem_q <= trial[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

[sv/rpn_integer_stack_evaluator.sv]
// Pushes and all operators but divide/modulo register their result in the cycle after the command
// is accepted. Divide and modulo by a nonzero divisor run in the bit-serial divider, which makes
// one quotient bit per cycle over 32 bits; no new command is accepted while it is busy.
// Other commands sustain one per cycle while results are taken.
// Reset clears depth, error count and handshake state; stack cells are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rpn_integer_stack_evaluator import rpn_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rpn_in_if.sink     in_ch,
	rpn_out_if.source  out_ch
);

	localparam int SP_W = $clog2(STACK_DEPTH + 1);

	logic [SP_W-1:0]  sp_q;
	logic [SP_W-1:0]  sp_next;
	logic [ERR_W-1:0] err_q;
	logic [ERR_W:0]   err_sum;
	logic [1:0]       err_inc;
	logic             out_valid_q;
	logic [CMD_W-1:0] cmd_q;
	logic [CMD_W-1:0] cmd_c;

	word_t            cell_val [STACK_DEPTH];
	cell_sel_t        cell_sel [STACK_DEPTH];

	div_req_t         div_req;
	div_rsp_t         div_rsp;

	logic             fire;
	logic             commit;
	logic             is_push;
	logic             is_unary;
	logic             is_bin;
	logic             is_divop;
	logic             full;
	logic             underflow;
	logic             overflow;
	logic             div_zero;
	logic             changes_top;
	word_t            a_op;
	word_t            b_op;
	word_t            alu_res;
	word_t            op_res;
	word_t            new_val;
	logic [SP_W+DEPTH_OUT_W-1:0] sp_ext;

	// Accept while the divider is idle and the result slot is free or emptying
	assign in_ch.ready = !div_rsp.busy && (!out_valid_q || out_ch.ready);
	assign fire        = in_ch.valid && in_ch.ready;

	// Decode the command being committed
	assign cmd_c    = div_rsp.busy ? cmd_q : in_ch.cmd;
	assign is_push  = (cmd_c == CMD_PUSH_LIT) || (cmd_c == CMD_PUSH_TIME);
	assign is_unary = (cmd_c == CMD_NOT);
	assign is_divop = (cmd_c == CMD_DIV) || (cmd_c == CMD_MOD);
	assign is_bin   = (cmd_c >= CMD_ADD) && (cmd_c <= CMD_LOR) && !is_unary;
	assign full     = (sp_q == SP_W'(STACK_DEPTH));

	// Missing operands read as zero
	assign b_op = (sp_q >= SP_W'(1)) ? cell_val[0] : '0;
	assign a_op = (sp_q >= SP_W'(2)) ? cell_val[1] : '0;

	rpn_alu u_alu (
		.cmd    (cmd_c),
		.a      (a_op),
		.b      (b_op),
		.result (alu_res)
	);

	assign div_req.start    = fire && is_divop && (b_op != '0);
	assign div_req.dividend = a_op;
	assign div_req.divisor  = b_op;

	rpn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign commit = (fire && !div_req.start) || div_rsp.done;

	assign op_res  = div_rsp.done ? ((cmd_q == CMD_MOD) ? div_rsp.remainder : div_rsp.quotient)
	                              : alu_res;
	assign new_val = is_push ? ((cmd_c == CMD_PUSH_LIT) ? in_ch.literal : in_ch.time_value)
	                         : op_res;

	// Error events of this step
	assign underflow = (is_bin && (sp_q < SP_W'(2))) || (is_unary && (sp_q == '0));
	assign overflow  = is_push && full;
	assign div_zero  = is_divop && (b_op == '0);
	assign err_inc   = 2'(underflow) + 2'(overflow) + 2'(div_zero);
	assign err_sum   = {1'b0, err_q} + (ERR_W+1)'(err_inc);

	// Next depth
	always_comb begin
		sp_next = sp_q;
		if (is_push) begin
			if (!full) begin
				sp_next = sp_q + 1'b1;
			end
		end else if (is_unary) begin
			if (sp_q == '0) begin
				sp_next = SP_W'(1);
			end
		end else if (is_bin) begin
			sp_next = (sp_q < SP_W'(2)) ? SP_W'(1) : (sp_q - 1'b1);
		end
	end

	assign changes_top = (is_push && !full) || is_unary || is_bin;

	// Steer each cell: push shifts down, binary op shifts up under a new top, NOT replaces the top
	always_comb begin
		for (int i = 0; i < STACK_DEPTH; i++) begin
			cell_sel[i] = CELL_HOLD;
			if (commit && changes_top) begin
				if (i == 0 || is_push) begin
					cell_sel[i] = CELL_FROM_UP;
				end else if (is_bin) begin
					cell_sel[i] = CELL_FROM_DOWN;
				end
			end
		end
	end

	// Row of stack cells, top at index zero
	for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
		word_t up_w;
		word_t down_w;

		if (g == 0) begin : g_first
			assign up_w = new_val;
		end else begin : g_mid
			assign up_w = cell_val[g-1];
		end

		if (g == STACK_DEPTH - 1) begin : g_last
			assign down_w = '0;
		end else begin : g_inner
			assign down_w = cell_val[g+1];
		end

		rpn_cell u_cell (
			.clk       (clk),
			.sel       (cell_sel[g]),
			.from_up   (up_w),
			.from_down (down_w),
			.value     (cell_val[g])
		);
	end

	// Depth, error count and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			err_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				sp_q        <= sp_next;
				err_q       <= err_sum[ERR_W] ? ERR_MAX : err_sum[ERR_W-1:0];
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the command for a divide in flight
	always_ff @(posedge clk) begin
		if (div_req.start) begin
			cmd_q <= in_ch.cmd;
		end
	end

	// State holds until the result is taken, so the outputs read it directly
	assign sp_ext             = {{DEPTH_OUT_W{1'b0}}, sp_q};
	assign out_ch.valid       = out_valid_q;
	assign out_ch.top_value   = (sp_q == '0) ? '0 : cell_val[0];
	assign out_ch.stack_depth = sp_ext[DEPTH_OUT_W-1:0];
	assign out_ch.error_count = err_q;

	a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> !in_ch.ready)
		else $error("command accepted while divider busy");

	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!out_valid_q || out_ch.ready))
		else $error("result overwritten before it was taken");

	a_commit_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("committed step produced no result");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_err_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> err_q >= $past(err_q))
		else $error("error count decreased");

endmodule

`default_nettype wire

[tb/rpn_result_checker.sv]
// Result checker: predicts the evaluator's stack state and compares every result item.
`timescale 1ns / 1ps

module rpn_result_checker import rpn_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rpn_in_if           cmd_bus,
	rpn_out_if          res_bus,
	output int unsigned fail_count,
	output int unsigned pending_results
);

	typedef struct packed {
		word_t                  top;
		logic [DEPTH_OUT_W-1:0] depth;
		logic [ERR_W-1:0]       errs;
	} stack_view_t;

	word_t            stack_mem [STACK_DEPTH];
	int unsigned      stack_fill = 0;
	logic [ERR_W-1:0] fault_cnt  = '0;
	stack_view_t      expected_views [$];

	// Saturating fault counter
	function automatic void count_fault();
		if (fault_cnt != ERR_MAX)
			fault_cnt = fault_cnt + 1'b1;
	endfunction

	// Drop the push and count a fault when the stack is full
	function automatic void stack_push(input word_t v);
		if (stack_fill >= STACK_DEPTH) begin
			count_fault();
		end else begin
			stack_mem[stack_fill] = v;
			stack_fill++;
		end
	endfunction

	// A missing operand reads as zero
	function automatic word_t stack_pop();
		if (stack_fill == 0)
			return '0;
		stack_fill--;
		return stack_mem[stack_fill];
	endfunction

	// Apply one command to the predicted stack and return the view it leaves behind
	function automatic stack_view_t predict_step(input logic [CMD_W-1:0] c, input word_t lit,
		input word_t tv);
		word_t       a;
		word_t       b;
		word_t       r;
		stack_view_t view;
		case (c)
			CMD_PUSH_LIT: stack_push(lit);
			CMD_PUSH_TIME: stack_push(tv);
			CMD_NOT: begin
				if (stack_fill < 1)
					count_fault();
				stack_push(~stack_pop());
			end
			default: begin
				// codes past the last operator leave the state alone
				if (c <= CMD_LOR) begin
					if (stack_fill < 2)
						count_fault();
					b = stack_pop();
					a = stack_pop();
					case (c)
						CMD_ADD: r = a + b;
						CMD_SUB: r = a - b;
						CMD_MUL: r = a * b;
						CMD_DIV: begin
							if (b == '0) begin
								count_fault();
								r = '0;
							end else begin
								r = a / b;
							end
						end
						CMD_MOD: begin
							if (b == '0) begin
								count_fault();
								r = '0;
							end else begin
								r = a % b;
							end
						end
						CMD_SHL: r = (b >= WORD_W) ? '0 : (a << b[SH_W-1:0]);
						CMD_SHR: r = (b >= WORD_W) ? '0 : (a >> b[SH_W-1:0]);
						CMD_AND: r = a & b;
						CMD_XOR: r = a ^ b;
						CMD_OR: r = a | b;
						CMD_EQ: r = word_t'(a == b);
						CMD_NE: r = word_t'(a != b);
						CMD_GT: r = word_t'(a > b);
						CMD_LT: r = word_t'(a < b);
						CMD_LE: r = word_t'(a <= b);
						CMD_GE: r = word_t'(a >= b);
						CMD_LAND: r = word_t'((a != '0) && (b != '0));
						CMD_LOR: r = word_t'((a != '0) || (b != '0));
						default: r = '0;
					endcase
					stack_push(r);
				end
			end
		endcase
		view.top   = (stack_fill == 0) ? '0 : stack_mem[stack_fill-1];
		view.depth = DEPTH_OUT_W'(stack_fill);
		view.errs  = fault_cnt;
		return view;
	endfunction

	// Check results before predicting, so a result is never matched to its own command
	always @(posedge clk) begin
		stack_view_t want;
		if (!arst_n) begin
			stack_fill = 0;
			fault_cnt  = '0;
			expected_views.delete();
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (expected_views.size() == 0) begin
					$error("result item with no command outstanding");
					fail_count++;
				end else begin
					want = expected_views.pop_front();
					if (res_bus.top_value !== want.top) begin
						$error("top_value: expected %h, got %h", want.top, res_bus.top_value);
						fail_count++;
					end
					if (res_bus.stack_depth !== want.depth) begin
						$error("stack_depth: expected %0d, got %0d", want.depth,
							res_bus.stack_depth);
						fail_count++;
					end
					if (res_bus.error_count !== want.errs) begin
						$error("error_count: expected %0d, got %0d", want.errs,
							res_bus.error_count);
						fail_count++;
					end
				end
			end
			if (cmd_bus.valid && cmd_bus.ready)
				expected_views.push_back(predict_step(cmd_bus.cmd, cmd_bus.literal,
					cmd_bus.time_value));
		end
		pending_results = expected_views.size();
	end

endmodule

[tb/tb_rpn_integer_stack_evaluator.sv]
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module tb_rpn_integer_stack_evaluator;

	import rpn_pkg::*;

	localparam int          STACK_LIMIT      = 16;
	localparam int unsigned MAIN_ITEMS       = 200;
	localparam int unsigned TAIL_ITEMS       = 40;
	localparam int unsigned SATURATE_ITEMS   = 135;
	localparam int unsigned DRAIN_CYCLES     = 40;
	localparam longint      RUN_LIMIT_NS     = 2_000_000;

	localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_LOR + 1'b1;
	localparam logic [CMD_W-1:0] CMD_LAST_CODE    = '1;

	logic clk;
	logic arst_n;

	rpn_in_if  cmd_bus ();
	rpn_out_if res_bus ();

	int unsigned fail_count;
	int unsigned pending_results;

	int unsigned burst_left   = 0;
	int unsigned depth_est    = 0;
	int unsigned target_depth = 4;

	rpn_integer_stack_evaluator #(
		.STACK_DEPTH(STACK_LIMIT)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (cmd_bus),
		.out_ch(res_bus)
	);

	rpn_result_checker #(
		.STACK_DEPTH(STACK_LIMIT)
	) result_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_bus        (cmd_bus),
		.res_bus        (res_bus),
		.fail_count     (fail_count),
		.pending_results(pending_results)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

	// Result back-pressure: switch between stall patterns at random intervals
	initial begin
		int unsigned mode;
		int unsigned mode_left;
		int unsigned tick;
		mode_left = 0;
		tick      = 0;
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			tick++;
			case (mode)
				0: res_bus.ready = 1'b1;
				1: res_bus.ready = $urandom_range(0, 1);
				2: res_bus.ready = (tick % 4) != 0;
				default: res_bus.ready = (tick % 24) >= 16;
			endcase
		end
	end

	// Operand mix: small values reach shift and divide corners, the rest spans the word
	function automatic word_t pick_operand();
		case ($urandom_range(0, 7))
			0, 1, 2: return word_t'($urandom_range(0, 40));
			3: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return word_t'(1);
					2: return '1;
					default: return {1'b1, {(WORD_W-1){1'b0}}};
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Present one command item in bursts and hold it until accepted
	task automatic send_cmd(input logic [CMD_W-1:0] c, input word_t lit, input word_t tv);
		@(negedge clk);
		if (burst_left == 0) begin
			cmd_bus.valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 8);
		end
		cmd_bus.valid      = 1'b1;
		cmd_bus.cmd        = c;
		cmd_bus.literal    = lit;
		cmd_bus.time_value = tv;
		do @(posedge clk); while (!cmd_bus.ready);
		burst_left--;
		// track depth to steer the random mix
		if (c == CMD_PUSH_LIT || c == CMD_PUSH_TIME)
			depth_est = (depth_est < STACK_LIMIT) ? depth_est + 1 : depth_est;
		else if (c == CMD_NOT)
			depth_est = (depth_est == 0) ? 1 : depth_est;
		else if (c <= CMD_LOR)
			depth_est = (depth_est < 2) ? 1 : depth_est - 1;
	endtask

	// Mostly well-formed postfix streams around a wandering target depth, some noise
	task automatic random_run(input int unsigned count);
		logic [CMD_W-1:0] c;
		int unsigned      roll;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 20 == 0)
				target_depth = $urandom_range(0, STACK_LIMIT + 2);
			roll = $urandom_range(0, 99);
			if (roll < 6)
				c = CMD_W'($urandom_range(0, CMD_LAST_CODE));
			else if ((depth_est < target_depth) ? (roll < 80) : (roll < 20))
				c = ($urandom_range(0, 3) == 0) ? CMD_PUSH_TIME : CMD_PUSH_LIT;
			else
				c = CMD_W'($urandom_range(CMD_ADD, CMD_LOR));
			send_cmd(c, pick_operand(), pick_operand());
		end
	endtask

	// Stimulus and verdict
	initial begin
		arst_n             = 1'b0;
		cmd_bus.valid      = 1'b0;
		cmd_bus.cmd        = CMD_PUSH_LIT;
		cmd_bus.literal    = '0;
		cmd_bus.time_value = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: underflow, divide and modulo by zero, word extremes, shift limits
		send_cmd(CMD_ADD, $urandom, $urandom);
		send_cmd(CMD_NOT, $urandom, $urandom);
		send_cmd(CMD_PUSH_LIT, '0, $urandom);
		send_cmd(CMD_DIV, $urandom, $urandom);
		send_cmd(CMD_PUSH_LIT, '1, $urandom);
		send_cmd(CMD_PUSH_TIME, $urandom, {1'b1, {(WORD_W-1){1'b0}}});
		send_cmd(CMD_MUL, $urandom, $urandom);
		send_cmd(CMD_PUSH_LIT, word_t'(WORD_W - 1), $urandom);
		send_cmd(CMD_SHL, $urandom, $urandom);
		send_cmd(CMD_PUSH_LIT, word_t'(WORD_W), $urandom);
		send_cmd(CMD_SHR, $urandom, $urandom);
		send_cmd(CMD_PUSH_LIT, '1, $urandom);
		send_cmd(CMD_SUB, $urandom, $urandom);
		send_cmd(CMD_PUSH_LIT, '0, $urandom);
		send_cmd(CMD_MOD, $urandom, $urandom);
		send_cmd(CMD_PUSH_LIT, word_t'(7), $urandom);
		send_cmd(CMD_XOR, $urandom, $urandom);
		send_cmd(CMD_OR, $urandom, $urandom);
		send_cmd(CMD_EQ, $urandom, $urandom);
		send_cmd(CMD_NE, $urandom, $urandom);
		send_cmd(CMD_GT, $urandom, $urandom);
		send_cmd(CMD_LT, $urandom, $urandom);
		send_cmd(CMD_LE, $urandom, $urandom);
		send_cmd(CMD_GE, $urandom, $urandom);
		send_cmd(CMD_AND, $urandom, $urandom);
		send_cmd(CMD_LAND, $urandom, $urandom);
		send_cmd(CMD_LOR, $urandom, $urandom);
		send_cmd(CMD_FIRST_UNUSED, $urandom, $urandom);
		send_cmd(CMD_LAST_CODE, $urandom, $urandom);

		random_run(MAIN_ITEMS);

		// Drive the error counter into saturation: divide by zero on a near-empty stack
		while (depth_est > 1)
			send_cmd(CMD_LAND, pick_operand(), pick_operand());
		repeat (SATURATE_ITEMS)
			send_cmd(($urandom_range(0, 1) != 0) ? CMD_DIV : CMD_MOD, $urandom, $urandom);

		random_run(TAIL_ITEMS);

		@(negedge clk);
		cmd_bus.valid = 1'b0;
		wait (pending_results == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
